// ===== rtl/u2u8e_pkg.sv =====
// ----------------------------------------------------------------------------
// u2u8e_pkg
// shared types, constants and byte encoding functions for the utf-16 to
// utf-8 escaper
// ----------------------------------------------------------------------------
package u2u8e_pkg;

  localparam int unsigned UNIT_W = 16;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned BYTE_W = 8;

  // surrogate prefixes in the top six bits of a code unit
  localparam logic [5:0] HIGH_SUR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SUR_TAG  = 6'b110111;

  localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

  localparam logic [CP_W-1:0] CP_CTRL_END = 21'h20;
  localparam logic [CP_W-1:0] CP_BSLASH   = 21'h5C;
  localparam logic [CP_W-1:0] CP_DQUOTE   = 21'h22;
  localparam logic [CP_W-1:0] CP_DEL      = 21'h7F;
  localparam logic [CP_W-1:0] CP_TWO_BYTE = 21'h80;
  localparam logic [CP_W-1:0] CP_THREE_BYTE = 21'h800;
  localparam logic [CP_W-1:0] CP_FOUR_BYTE  = 21'h10000;

  localparam logic [BYTE_W-1:0] CHAR_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CHAR_X      = 8'h78;
  localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_A_OFS  = 8'h57;  // 'a' minus ten

  // sequence index of the last byte of a three byte sequence
  localparam logic [1:0] PRE_LAST_IDX = 2'd2;

  // one queue entry: an optional released high surrogate, then an optional
  // code point, each expanded to bytes by the back end
  typedef struct packed {
    logic              has_pre;
    logic [UNIT_W-1:0] pre_unit;
    logic              has_main;
    logic [CP_W-1:0]   main_cp;
    logic [1:0]        main_len_m1;
  } job_t;

  function automatic logic is_escape(input logic [CP_W-1:0] cp);
    return (cp < CP_CTRL_END) || (cp == CP_BSLASH) || (cp == CP_DQUOTE) ||
           (cp == CP_DEL);
  endfunction

  function automatic logic [1:0] enc_len_m1(input logic [CP_W-1:0] cp);
    logic [1:0] len;
    if (is_escape(cp)) begin
      len = 2'd3;
    end else if (cp < CP_TWO_BYTE) begin
      len = 2'd0;
    end else if (cp < CP_THREE_BYTE) begin
      len = 2'd1;
    end else if (cp < CP_FOUR_BYTE) begin
      len = 2'd2;
    end else begin
      len = 2'd3;
    end
    return len;
  endfunction

  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] v);
    logic [BYTE_W-1:0] d;
    if (v < 4'd10) begin
      d = CHAR_ZERO + {4'h0, v};
    end else begin
      d = CHAR_A_OFS + {4'h0, v};
    end
    return d;
  endfunction

  function automatic logic [BYTE_W-1:0] enc_byte(input logic [CP_W-1:0] cp,
                                                 input logic [1:0] idx);
    logic [BYTE_W-1:0] b;
    b = '0;
    if (is_escape(cp)) begin
      case (idx)
        2'd0:    b = CHAR_BSLASH;
        2'd1:    b = CHAR_X;
        2'd2:    b = hex_digit(cp[7:4]);
        default: b = hex_digit(cp[3:0]);
      endcase
    end else if (cp < CP_TWO_BYTE) begin
      b = cp[7:0];
    end else if (cp < CP_THREE_BYTE) begin
      case (idx)
        2'd0:    b = {3'b110, cp[10:6]};
        default: b = {2'b10, cp[5:0]};
      endcase
    end else if (cp < CP_FOUR_BYTE) begin
      case (idx)
        2'd0:    b = {4'b1110, cp[15:12]};
        2'd1:    b = {2'b10, cp[11:6]};
        default: b = {2'b10, cp[5:0]};
      endcase
    end else begin
      case (idx)
        2'd0:    b = {5'b11110, cp[20:18]};
        2'd1:    b = {2'b10, cp[17:12]};
        2'd2:    b = {2'b10, cp[11:6]};
        default: b = {2'b10, cp[5:0]};
      endcase
    end
    return b;
  endfunction

endpackage

// ===== rtl/u2u8e_front.sv =====
// ----------------------------------------------------------------------------
// u2u8e_front
// accepts code units, pairs surrogates and queues encode jobs
// ----------------------------------------------------------------------------
module u2u8e_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [u2u8e_pkg::UNIT_W-1:0]        code_unit,
  input  logic                                last_unit,
  input  logic                                q_ready,
  output logic                                push,
  output u2u8e_pkg::job_t                     job
);

  logic                         held_valid;
  logic [u2u8e_pkg::UNIT_W-1:0] held_high;
  logic                         is_high;
  logic                         is_low;
  logic                         accept;
  logic                         pair;
  logic                         hold_now;

  assign is_high  = code_unit[15:10] == u2u8e_pkg::HIGH_SUR_TAG;
  assign is_low   = code_unit[15:10] == u2u8e_pkg::LOW_SUR_TAG;
  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign pair     = held_valid && is_low;
  assign hold_now = !pair && is_high && !last_unit;

  always_comb begin
    job.has_pre  = held_valid && !is_low;
    job.pre_unit = held_high;
    job.has_main = !hold_now;
    if (pair) begin
      job.main_cp = u2u8e_pkg::SUPP_BASE + {1'b0, held_high[9:0], code_unit[9:0]};
    end else begin
      job.main_cp = {5'b0, code_unit};
    end
    job.main_len_m1 = u2u8e_pkg::enc_len_m1(job.main_cp);
  end

  // nothing is queued when a high surrogate is only being held
  assign push = accept && (job.has_pre || job.has_main);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_high  <= '0;
    end else if (accept) begin
      held_valid <= hold_now;
      held_high  <= hold_now ? code_unit : '0;
    end
  end

endmodule

// ===== rtl/u2u8e_queue.sv =====
// ----------------------------------------------------------------------------
// u2u8e_queue
// small first-in first-out queue of encode jobs
// ----------------------------------------------------------------------------
module u2u8e_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u2u8e_pkg::job_t push_data,
  output logic            not_full,
  input  logic            pop,
  output logic            not_empty,
  output u2u8e_pkg::job_t head
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  u2u8e_pkg::job_t entries [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign not_full  = count != CW'(DEPTH);
  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/u2u8e_back.sv =====
// ----------------------------------------------------------------------------
// u2u8e_back
// expands queued jobs into registered bytes, one per cycle unless stalled
// ----------------------------------------------------------------------------
module u2u8e_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_not_empty,
  input  u2u8e_pkg::job_t               head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [u2u8e_pkg::BYTE_W-1:0]  out_byte,
  output logic                          run_last
);

  logic [1:0]                   idx;
  logic                         pre_done;
  logic                         in_pre;
  logic                         part_end;
  logic                         job_end;
  logic                         advance;
  logic [u2u8e_pkg::CP_W-1:0]   cur_cp;
  logic [1:0]                   cur_last_idx;

  assign in_pre       = head.has_pre && !pre_done;
  assign cur_cp       = in_pre ? {5'b0, head.pre_unit} : head.main_cp;
  assign cur_last_idx = in_pre ? u2u8e_pkg::PRE_LAST_IDX : head.main_len_m1;
  assign part_end     = idx == cur_last_idx;
  assign job_end      = part_end && (!in_pre || !head.has_main);
  assign advance      = q_not_empty && (!out_valid || out_ready);
  assign pop          = advance && job_end;

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= u2u8e_pkg::enc_byte(cur_cp, idx);
      run_last <= job_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      pre_done  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        if (part_end) begin
          idx      <= '0;
          pre_done <= !job_end;
        end else begin
          idx <= idx + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/utf16_to_utf8_escaper_top.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_escaper_top
// streaming utf-16 to utf-8 converter with escaping of special characters
// ----------------------------------------------------------------------------
// Each accepted code unit yields zero to seven output bytes; run_last marks
// the final byte caused by a transaction. A code unit is taken in every cycle
// while the job queue (QUEUE_DEPTH entries) has room, and the output side
// moves one byte per cycle while out_ready allows, so the sustained rate is
// set by the byte serializer and by how many bytes each unit produces (one
// for ascii, two or three for the basic plane, four for an escape or a pair,
// none when a high surrogate is held, seven at most). The first byte of a
// unit passes through the job queue and then the registered output.
module utf16_to_utf8_escaper_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // input code units
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] code_unit,
  input  logic        last_unit,
  // output bytes
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        run_last
);

  // jobs from the classifier to the serializer
  u2u8e_pkg::job_t push_job;
  u2u8e_pkg::job_t head_job;
  logic            push;
  logic            pop;
  logic            q_not_full;
  logic            q_not_empty;

  // front: surrogate pairing and the held high surrogate
  u2u8e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .code_unit (code_unit),
    .last_unit (last_unit),
    .q_ready   (q_not_full),
    .push      (push),
    .job       (push_job)
  );

  // decouples acceptance of units from the byte rate
  u2u8e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .not_full  (q_not_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (head_job)
  );

  // back: one byte per cycle into the output register unless it is stalled
  u2u8e_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .head        (head_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .run_last    (run_last)
  );

endmodule

// ===== rtl/u2u8e_checker.sv =====
// ----------------------------------------------------------------------------
// u2u8e_checker
// port level checks for the utf-16 to utf-8 escaper
// ----------------------------------------------------------------------------
module u2u8e_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [15:0] code_unit,
  input logic        last_unit,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        run_last
);

  // no output right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
    else $error("stalled output changed");

  // a backslash or a lead byte never ends a transaction's bytes
  a_no_end_on_lead: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_byte == 8'h5C || out_byte[7:6] == 2'b11) |-> !run_last)
    else $error("sequence ended on a lead byte");

  // bytes never seen in well formed utf-8 output
  a_legal_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_byte[7:3] != 5'b11111 && out_byte[7:1] != 7'b1100000)
    else $error("illegal utf-8 byte");

endmodule

bind utf16_to_utf8_escaper_top u2u8e_checker u_chk (.*);

// ===== tb/sv/utf16_to_utf8_escaper_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_escaper_top_tb
// feeds utf-16 code units into the escaper and checks every byte that comes
// out against an in-bench model of the utf-8 encoding and escape rules
// ----------------------------------------------------------------------------

// one expected output byte, with the flag that closes a transaction's bytes
typedef struct packed {
  logic [7:0] value;
  logic       tail;
} utf8_byte_t;

// tracks the held surrogate and the bytes still owed by the block
class utf8_byte_tracker;
  logic [15:0] held_high;
  logic        held_valid;
  utf8_byte_t  pending_bytes[$];
  utf8_byte_t  step_bytes[$];
  int          mismatches;

  function new();
    held_high  = '0;
    held_valid = 1'b0;
    mismatches = 0;
  endfunction

  function void push_byte(logic [7:0] b);
    utf8_byte_t e;
    e.value = b;
    e.tail  = 1'b0;
    step_bytes.push_back(e);
  endfunction

  function logic [7:0] hex_char(logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'h0, nib};
    end else begin
      c = 8'h61 + {4'h0, nib} - 8'd10;
    end
    return c;
  endfunction

  // utf-8 bytes, or a backslash-x escape, for one code point
  function void push_point(logic [20:0] cp);
    if (cp < u2u8e_pkg::CP_CTRL_END || cp == u2u8e_pkg::CP_BSLASH ||
        cp == u2u8e_pkg::CP_DQUOTE || cp == u2u8e_pkg::CP_DEL) begin
      push_byte(u2u8e_pkg::CHAR_BSLASH);
      push_byte(u2u8e_pkg::CHAR_X);
      push_byte(hex_char(cp[7:4]));
      push_byte(hex_char(cp[3:0]));
    end else if (cp < 21'h80) begin
      push_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      push_byte(8'hC0 | {3'b000, cp[10:6]});
      push_byte(8'h80 | {2'b00, cp[5:0]});
    end else if (cp < 21'h10000) begin
      push_byte(8'hE0 | {4'h0, cp[15:12]});
      push_byte(8'h80 | {2'b00, cp[11:6]});
      push_byte(8'h80 | {2'b00, cp[5:0]});
    end else begin
      push_byte(8'hF0 | {5'd0, cp[20:18]});
      push_byte(8'h80 | {2'b00, cp[17:12]});
      push_byte(8'h80 | {2'b00, cp[11:6]});
      push_byte(8'h80 | {2'b00, cp[5:0]});
    end
  endfunction

  function void note_unit(logic [15:0] cu, logic lu);
    logic       is_high;
    logic       is_low;
    utf8_byte_t e;
    is_high = (cu[15:10] == u2u8e_pkg::HIGH_SUR_TAG);
    is_low  = (cu[15:10] == u2u8e_pkg::LOW_SUR_TAG);
    step_bytes.delete();
    if (held_valid && is_low) begin
      push_point(u2u8e_pkg::SUPP_BASE + {1'b0, held_high[9:0], cu[9:0]});
      held_valid = 1'b0;
      held_high  = '0;
    end else begin
      if (held_valid) begin
        push_point({5'd0, held_high});
        held_valid = 1'b0;
        held_high  = '0;
      end
      if (is_high && !lu) begin
        held_high  = cu;
        held_valid = 1'b1;
      end else begin
        push_point({5'd0, cu});
      end
    end
    if (step_bytes.size() > 0) begin
      e = step_bytes[step_bytes.size()-1];
      e.tail = 1'b1;
      step_bytes[step_bytes.size()-1] = e;
    end
    foreach (step_bytes[i]) begin
      pending_bytes.push_back(step_bytes[i]);
    end
  endfunction

  function void check_byte(logic [7:0] b, logic tl);
    utf8_byte_t want;
    if (pending_bytes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: unexpected byte %h run_last %b, nothing pending", $time, b, tl);
      end
    end else begin
      want = pending_bytes.pop_front();
      if (want.value !== b || want.tail !== tl) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: byte mismatch, expected %h run_last %b, got %h run_last %b",
                   $time, want.value, want.tail, b, tl);
        end
      end
    end
  endfunction
endclass

module utf16_to_utf8_escaper_top_tb;

  localparam int TOTAL_UNITS    = 330;
  localparam int CALM_FROM      = 280;   // no idling on either side past this
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] code_unit;
  logic        last_unit;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        run_last;

  logic calm;        // set for the last part of the run
  int   units_sent;

  utf8_byte_tracker tracker = new();

  utf16_to_utf8_escaper_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .code_unit (code_unit),
    .last_unit (last_unit),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_last  (run_last)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one code unit transaction, with an optional idle burst in front
  // valid stays high from one unit to the next when no burst comes between
  task automatic send_unit(input logic [15:0] cu, input logic lu);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    code_unit <= cu;
    last_unit <= lu;
    // in_ready read here is its value just before this edge
    do @(posedge clk); while (!in_ready);
    units_sent++;
  endtask

  // monitor: both handshakes are sampled at the edge, before any update
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        tracker.note_unit(code_unit, last_unit);
      end
      if (out_valid && out_ready) begin
        tracker.check_byte(out_byte, run_last);
      end
    end
  end

  // byte sink: stalls in random bursts, with ready runs between
  initial begin
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // watchdog: a long stretch without any transaction ends the run
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: watchdog, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("utf16_to_utf8_escaper_top_tb: errors");
    $finish;
  end

  // stimulus
  initial begin
    logic [15:0] u;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    code_unit  <= '0;
    last_unit  <= 1'b0;
    calm       = 1'b0;
    units_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // single units at the class boundaries: escapes, ascii, two and three bytes
    send_unit(16'h0000, 1'b0);
    send_unit(16'h001F, 1'b0);
    send_unit(16'h0020, 1'b0);
    send_unit(16'h0022, 1'b0);
    send_unit(16'h005C, 1'b0);
    send_unit(16'h007E, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    // lowest and highest surrogate pairs
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    // high surrogate as the last unit of a string is never held
    send_unit(16'hD800, 1'b1);
    // held unit released by a plain character
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'h0041, 1'b0);
    // held unit released by an escape: the longest burst of bytes
    send_unit(16'hD812, 1'b0);
    send_unit(16'h005C, 1'b0);
    // held unit released by another high surrogate, which then pairs
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDB00, 1'b0);
    send_unit(16'hDC05, 1'b1);
    // lone low surrogates, then the first unit past the surrogate range
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDFFF, 1'b0);
    send_unit(16'hE000, 1'b1);

    // random text, mostly well formed, with some noise and broken pairs
    while (units_sent < TOTAL_UNITS) begin
      if (units_sent >= CALM_FROM) begin
        calm = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          send_unit(16'($urandom_range(16'h20, 16'h7E)), $urandom_range(0, 7) == 0);
        end
        3: begin
          case ($urandom_range(0, 3))
            0:       u = 16'($urandom_range(0, 31));
            1:       u = 16'h0022;
            2:       u = 16'h005C;
            default: u = 16'h007F;
          endcase
          send_unit(u, $urandom_range(0, 7) == 0);
        end
        4: begin
          send_unit(16'($urandom_range(16'h80, 16'h7FF)), $urandom_range(0, 7) == 0);
        end
        5: begin
          if ($urandom_range(0, 1) == 0) begin
            u = 16'($urandom_range(16'h800, 16'hD7FF));
          end else begin
            u = 16'($urandom_range(16'hE000, 16'hFFFF));
          end
          send_unit(u, $urandom_range(0, 7) == 0);
        end
        6, 7: begin
          // well-formed pair with random content
          send_unit(16'hD800 + 16'($urandom_range(0, 1023)), 1'b0);
          send_unit(16'hDC00 + 16'($urandom_range(0, 1023)), $urandom_range(0, 7) == 0);
        end
        8: begin
          send_unit(16'($urandom), $urandom_range(0, 1) == 0);
        end
        default: begin
          // broken pair: lone high or lone low, at or away from string end
          if ($urandom_range(0, 1) == 0) begin
            u = 16'hD800 + 16'($urandom_range(0, 1023));
          end else begin
            u = 16'hDC00 + 16'($urandom_range(0, 1023));
          end
          send_unit(u, $urandom_range(0, 3) == 0);
        end
      endcase
    end
    in_valid <= 1'b0;

    // drain, then give stray bytes a chance to show up
    while (tracker.pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("utf16_to_utf8_escaper_top_tb: clean");
    end else begin
      $display("utf16_to_utf8_escaper_top_tb: errors");
    end
    $finish;
  end

endmodule
